// ===== rtl/tss_pkg.sv =====
// Shared types for the triangle scanline span pipeline.
package tss_pkg;

   // Control bits that travel with each word through the pipeline.
   typedef struct packed {
      logic valid;
      logic hit;
   } tss_ctl_type;

endpackage

// ===== rtl/triangle_scanline_span.sv =====
// Top level: scanline span of a filled triangle, fully pipelined.
//
//  channel | ports                                   | dir | handshake
//  --------+-----------------------------------------+-----+-------------------------
//  request | start, busy, req_vertex*_x/y, req_scan_row | in  | start && !busy
//  result  | rsp_strobe, rsp_covered, rsp_span_start,| out | rsp_strobe, one cycle
//          | rsp_span_width                          |     |
//
// One word enters per cycle while busy is low; its result passes through vertex
// sort, edge setup, multiply, one restoring divider stage per quotient bit,
// crossing add, then ordering and width. Throughput is one word per clock.
// Reset clears every valid bit at once; busy is high only while reset is high.
// The receiver cannot stall, so nothing inside ever holds: words just advance.
module triangle_scanline_span #(
   parameter int COORD_WIDTH = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_vertex0_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex0_y,
   input  logic signed [COORD_WIDTH-1:0] req_vertex1_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex1_y,
   input  logic signed [COORD_WIDTH-1:0] req_vertex2_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex2_y,
   input  logic signed [COORD_WIDTH-1:0] req_scan_row,
   output logic                          rsp_strobe,
   output logic                          rsp_covered,
   output logic signed [COORD_WIDTH-1:0] rsp_span_start,
   output logic [COORD_WIDTH:0]          rsp_span_width
);
   import tss_pkg::*;

   localparam int W       = COORD_WIDTH;
   localparam int LATENCY = W + 5;

   logic accept;

   // only reset holds the request side off
   assign busy   = reset;
   assign accept = start && !busy;

   // sort + setup: two stages
   tss_ctl_type         setup_ctl;
   logic signed [W-1:0] xa_a, xa_b;
   logic signed [W:0]   dx_a, dx_b;
   logic [W-1:0]        drow_a, drow_b, dy_a, dy_b;

   tss_setup #(.W(W)) u_setup (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_x0      (req_vertex0_x),
      .in_y0      (req_vertex0_y),
      .in_x1      (req_vertex1_x),
      .in_y1      (req_vertex1_y),
      .in_x2      (req_vertex2_x),
      .in_y2      (req_vertex2_y),
      .in_row     (req_scan_row),
      .out_ctl    (setup_ctl),
      .out_xa_a   (xa_a),
      .out_xa_b   (xa_b),
      .out_dx_a   (dx_a),
      .out_dx_b   (dx_b),
      .out_drow_a (drow_a),
      .out_drow_b (drow_b),
      .out_dy_a   (dy_a),
      .out_dy_b   (dy_b)
   );

   // edge A (0-1 or 1-2, else xmin with zero slope) carries the hit flag and its base x alongside
   logic         va_out, vb_out, neg_a, neg_b;
   logic [W:0]   tag_a_out;
   logic [W-1:0] tag_b_out, quot_a, quot_b;

   tss_edge_div #(.W(W), .TAG_W(W + 1)) u_div_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (setup_ctl.valid),
      .in_tag    ({setup_ctl.hit, xa_a}),
      .in_dx     (dx_a),
      .in_drow   (drow_a),
      .in_dy     (dy_a),
      .out_valid (va_out),
      .out_tag   (tag_a_out),
      .out_neg   (neg_a),
      .out_quot  (quot_a)
   );

   // edge B is the long edge 0-2, or xmax with zero slope for a one-row triangle or miss
   tss_edge_div #(.W(W), .TAG_W(W)) u_div_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (setup_ctl.valid),
      .in_tag    (xa_b),
      .in_dx     (dx_b),
      .in_drow   (drow_b),
      .in_dy     (dy_b),
      .out_valid (vb_out),
      .out_tag   (tag_b_out),
      .out_neg   (neg_b),
      .out_quot  (quot_b)
   );

   tss_ctl_type span_ctl;

   assign span_ctl.valid = va_out;
   assign span_ctl.hit   = tag_a_out[W];

   tss_span #(.W(W)) u_span (
      .clock       (clock),
      .reset       (reset),
      .in_ctl      (span_ctl),
      .in_xa_a     (tag_a_out[W-1:0]),
      .in_xa_b     (tag_b_out),
      .in_neg_a    (neg_a),
      .in_neg_b    (neg_b),
      .in_quot_a   (quot_a),
      .in_quot_b   (quot_b),
      .out_valid   (rsp_strobe),
      .out_covered (rsp_covered),
      .out_start   (rsp_span_start),
      .out_width   (rsp_span_width)
   );

   // both edge lanes run in lockstep
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      va_out == vb_out)
      else $error("edge divider lanes out of step");

   // no result word without a matching request word accepted earlier
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result word without matching request");

endmodule

// ===== rtl/tss_setup.sv =====
// Vertex sort stage and edge operand setup stage.
module tss_setup #(
   parameter int W = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [W-1:0]   in_x0,
   input  logic signed [W-1:0]   in_y0,
   input  logic signed [W-1:0]   in_x1,
   input  logic signed [W-1:0]   in_y1,
   input  logic signed [W-1:0]   in_x2,
   input  logic signed [W-1:0]   in_y2,
   input  logic signed [W-1:0]   in_row,
   output tss_pkg::tss_ctl_type  out_ctl,
   output logic signed [W-1:0]   out_xa_a,
   output logic signed [W-1:0]   out_xa_b,
   output logic signed [W:0]     out_dx_a,
   output logic signed [W:0]     out_dx_b,
   output logic [W-1:0]          out_drow_a,
   output logic [W-1:0]          out_drow_b,
   output logic [W-1:0]          out_dy_a,
   output logic [W-1:0]          out_dy_b
);
   import tss_pkg::*;

   // sort stage
   logic signed [W-1:0] px0, py0, px1, py1, qx1, qy1, qx2, qy2;
   logic signed [W-1:0] sx0_in, sy0_in, sx1_in, sy1_in;
   logic signed [W-1:0] sx0_ff, sy0_ff, sx1_ff, sy1_ff, sx2_ff, sy2_ff, srow_ff;
   logic                sval_ff;

   always_comb begin
      if (in_y0 > in_y1) begin
         px0 = in_x1; py0 = in_y1; px1 = in_x0; py1 = in_y0;
      end else begin
         px0 = in_x0; py0 = in_y0; px1 = in_x1; py1 = in_y1;
      end
      if (py1 > in_y2) begin
         qx1 = in_x2; qy1 = in_y2; qx2 = px1; qy2 = py1;
      end else begin
         qx1 = px1; qy1 = py1; qx2 = in_x2; qy2 = in_y2;
      end
      if (py0 > qy1) begin
         sx0_in = qx1; sy0_in = qy1; sx1_in = px0; sy1_in = py0;
      end else begin
         sx0_in = px0; sy0_in = py0; sx1_in = qx1; sy1_in = qy1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sval_ff <= 1'b0;
      end else begin
         sval_ff <= in_valid;
      end
      sx0_ff  <= sx0_in;
      sy0_ff  <= sy0_in;
      sx1_ff  <= sx1_in;
      sy1_ff  <= sy1_in;
      sx2_ff  <= qx2;
      sy2_ff  <= qy2;
      srow_ff <= in_row;
   end

   // setup stage
   logic signed [W:0]   ex0, ex1, ex2, ey0, ey1, ey2, erow;
   logic signed [W:0]   dx01, dx12, dx02, dr0, dr1, dy01, dy12, dy02;
   logic                flat, in_range, upper, hit_in;
   logic signed [W-1:0] xmin, xmax;
   logic signed [W-1:0] xa_a_in, xa_b_in;
   logic signed [W:0]   dx_a_in, dx_b_in;
   logic [W-1:0]        drow_a_in, drow_b_in, dy_a_in, dy_b_in;

   assign ex0  = {sx0_ff[W-1], sx0_ff};
   assign ex1  = {sx1_ff[W-1], sx1_ff};
   assign ex2  = {sx2_ff[W-1], sx2_ff};
   assign ey0  = {sy0_ff[W-1], sy0_ff};
   assign ey1  = {sy1_ff[W-1], sy1_ff};
   assign ey2  = {sy2_ff[W-1], sy2_ff};
   assign erow = {srow_ff[W-1], srow_ff};
   assign dx01 = ex1 - ex0;
   assign dx12 = ex2 - ex1;
   assign dx02 = ex2 - ex0;
   assign dr0  = erow - ey0;
   assign dr1  = erow - ey1;
   assign dy01 = ey1 - ey0;
   assign dy12 = ey2 - ey1;
   assign dy02 = ey2 - ey0;

   always_comb begin
      flat     = (sy0_ff == sy2_ff);
      in_range = (srow_ff >= sy0_ff) && (srow_ff <= sy2_ff);
      // upper part runs through y1 when the bottom is flat
      upper    = (srow_ff < sy1_ff) || (sy1_ff == sy2_ff);
      hit_in   = flat ? (srow_ff == sy0_ff) : in_range;

      xmin = sx0_ff;
      xmax = sx0_ff;
      if (sx1_ff < xmin) xmin = sx1_ff;
      if (sx1_ff > xmax) xmax = sx1_ff;
      if (sx2_ff < xmin) xmin = sx2_ff;
      if (sx2_ff > xmax) xmax = sx2_ff;

      // one-row triangle or miss: zero slope, divisor one, crossing = base x
      xa_a_in   = xmin;
      xa_b_in   = xmax;
      dx_a_in   = '0;
      dx_b_in   = '0;
      drow_a_in = '0;
      drow_b_in = '0;
      dy_a_in   = {{(W-1){1'b0}}, 1'b1};
      dy_b_in   = {{(W-1){1'b0}}, 1'b1};

      if (hit_in && !flat) begin
         xa_b_in   = sx0_ff;
         dx_b_in   = dx02;
         drow_b_in = dr0[W-1:0];
         dy_b_in   = dy02[W-1:0];
         if (upper) begin
            xa_a_in   = sx0_ff;
            dx_a_in   = dx01;
            drow_a_in = dr0[W-1:0];
            dy_a_in   = dy01[W-1:0];
         end else begin
            xa_a_in   = sx1_ff;
            dx_a_in   = dx12;
            drow_a_in = dr1[W-1:0];
            dy_a_in   = dy12[W-1:0];
         end
      end
   end

   logic val_ff, hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= 1'b0;
      end else begin
         val_ff <= sval_ff;
      end
      hit_ff     <= hit_in;
      out_xa_a   <= xa_a_in;
      out_xa_b   <= xa_b_in;
      out_dx_a   <= dx_a_in;
      out_dx_b   <= dx_b_in;
      out_drow_a <= drow_a_in;
      out_drow_b <= drow_b_in;
      out_dy_a   <= dy_a_in;
      out_dy_b   <= dy_b_in;
   end

   assign out_ctl.valid = val_ff;
   assign out_ctl.hit   = hit_ff;

endmodule

// ===== rtl/tss_edge_div.sv =====
// Edge crossing offset: |dx| * drow, then a restoring divider, one quotient bit per stage.
module tss_edge_div #(
   parameter int W     = 12,
   parameter int TAG_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [TAG_W-1:0]     in_tag,
   input  logic signed [W:0]    in_dx,
   input  logic [W-1:0]         in_drow,
   input  logic [W-1:0]         in_dy,
   output logic                 out_valid,
   output logic [TAG_W-1:0]     out_tag,
   output logic                 out_neg,
   output logic [W-1:0]         out_quot
);
   localparam int PW = 2 * W;
   localparam int NS = W + 1;

   logic             valid_ff [NS];
   logic [TAG_W-1:0] tag_ff   [NS];
   logic             neg_ff   [NS];
   logic [W-1:0]     dy_ff    [NS];
   logic [PW-1:0]    rem_ff   [NS];
   logic [W-1:0]     quot_ff  [NS];

   logic signed [W:0] dx_neg;
   logic [W-1:0]      mag;
   logic [PW-1:0]     prod_in;

   assign dx_neg  = -in_dx;
   assign mag     = in_dx[W] ? dx_neg[W-1:0] : in_dx[W-1:0];
   assign prod_in = PW'(mag) * PW'(in_drow);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      tag_ff[0]  <= in_tag;
      neg_ff[0]  <= in_dx[W];
      dy_ff[0]   <= in_dy;
      rem_ff[0]  <= prod_in;
      quot_ff[0] <= '0;
   end

   // stage k settles quotient bit W-1-k
   for (genvar k = 0; k < W; k++) begin : g_step
      logic [PW-1:0] dsh;
      logic          ge;

      assign dsh = {{W{1'b0}}, dy_ff[k]} << (W - 1 - k);
      assign ge  = (rem_ff[k] >= dsh);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         tag_ff[k+1]  <= tag_ff[k];
         neg_ff[k+1]  <= neg_ff[k];
         dy_ff[k+1]   <= dy_ff[k];
         rem_ff[k+1]  <= ge ? (rem_ff[k] - dsh) : rem_ff[k];
         quot_ff[k+1] <= {quot_ff[k][W-2:0], ge};
      end
   end

   assign out_valid = valid_ff[W];
   assign out_tag   = tag_ff[W];
   assign out_neg   = neg_ff[W];
   assign out_quot  = quot_ff[W];

   // quotient must fit W bits
   a_quot_fits: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (rem_ff[0] < {dy_ff[0], {W{1'b0}}}))
      else $error("edge product too large for quotient width");

   // final remainder below divisor
   a_rem_final: assert property (@(posedge clock) disable iff (reset)
      valid_ff[W] |-> (rem_ff[W] < PW'(dy_ff[W])))
      else $error("divider remainder not reduced");

endmodule

// ===== rtl/tss_span.sv =====
// Crossing add, left/right ordering and span width.
module tss_span #(
   parameter int W = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tss_pkg::tss_ctl_type  in_ctl,
   input  logic signed [W-1:0]   in_xa_a,
   input  logic signed [W-1:0]   in_xa_b,
   input  logic                  in_neg_a,
   input  logic                  in_neg_b,
   input  logic [W-1:0]          in_quot_a,
   input  logic [W-1:0]          in_quot_b,
   output logic                  out_valid,
   output logic                  out_covered,
   output logic signed [W-1:0]   out_start,
   output logic [W:0]            out_width
);
   import tss_pkg::*;

   logic signed [W:0] qa_pos, qb_pos, qa_s, qb_s, ca, cb;

   assign qa_pos = {1'b0, in_quot_a};
   assign qb_pos = {1'b0, in_quot_b};
   assign qa_s   = in_neg_a ? -qa_pos : qa_pos;
   assign qb_s   = in_neg_b ? -qb_pos : qb_pos;
   assign ca     = {in_xa_a[W-1], in_xa_a} + qa_s;
   assign cb     = {in_xa_b[W-1], in_xa_b} + qb_s;

   logic                va_ff, hit_ff;
   logic signed [W-1:0] a_ff, b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= in_ctl.valid;
      end
      hit_ff <= in_ctl.hit;
      a_ff   <= ca[W-1:0];
      b_ff   <= cb[W-1:0];
   end

   logic signed [W-1:0] lo, hi;
   logic [W:0]          wid;

   always_comb begin
      if (a_ff > b_ff) begin
         lo = b_ff;
         hi = a_ff;
      end else begin
         lo = a_ff;
         hi = b_ff;
      end
      wid = {hi[W-1], hi} - {lo[W-1], lo} + (W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= va_ff;
      end
      out_covered <= hit_ff;
      out_start   <= hit_ff ? lo : '0;
      out_width   <= hit_ff ? wid : '0;
   end

   a_cov_width: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_covered) |-> (out_width != '0))
      else $error("covered row with empty span");

   a_width_max: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_width[W]) |-> (out_width[W-1:0] == '0))
      else $error("span width beyond full row");

endmodule
